### src/mp2a_pkg.sv
// ----------------------------------------------------------------------------
// mp2a_pkg: shared types and constants for 2x2 max pooling with argmax
// Sizes, register indexes, the queue entry and the pair reduction.
// ----------------------------------------------------------------------------
package mp2a_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int LINE_DEPTH  = MAX_COLS / 2;
   localparam int IDX_W       = $clog2(LINE_DEPTH);
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int SIZE_W      = 11;
   localparam int VALUE_W     = 15;
   localparam int POS_W       = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ROWS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TRAINING = CSR_IDX_W'(2);

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_MERGE = 1'b1
   } op_kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0] best;
      logic               pos;
   } pair_type;

   typedef struct packed {
      op_kind_type        kind;
      pair_type           pair;
      logic [IDX_W-1:0]   idx;
      logic [ROW_W-2:0]   row_half;
      logic               train;
   } pool_op_type;

   // even size clamped to 2..maxv
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
      logic [SIZE_W-1:0] top;
      logic [SIZE_W-1:0] v_even;
      top    = SIZE_W'(maxv) & ~SIZE_W'(1);
      v_even = v & ~SIZE_W'(1);
      if (v_even < SIZE_W'(2)) begin
         return SIZE_W'(2);
      end else if (v_even > top) begin
         return top;
      end
      return v_even;
   endfunction

   // best of zero, left, right with strict compares; floor at zero
   function automatic pair_type pair_reduce(input logic signed [SAMPLE_BITS-1:0] left,
                                            input logic signed [SAMPLE_BITS-1:0] right);
      pair_type                       res;
      logic signed [SAMPLE_BITS-1:0]  best;
      best     = '0;
      res.pos  = 1'b0;
      if (left > best) begin
         best = left;
      end
      if (right > best) begin
         best    = right;
         res.pos = 1'b1;
      end
      res.best = VALUE_W'(best);
      return res;
   endfunction

endpackage

### src/mp2a_front.sv
// ----------------------------------------------------------------------------
// mp2a_front: raster position tracking and pair reduction
// Holds the left sample of each pair, reduces pairs and queues store or
// merge operations; owns the configuration registers.
// ----------------------------------------------------------------------------
module mp2a_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mp2a_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mp2a_pkg::SIZE_W-1:0]           csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  q_ready,
   output logic                                  q_push,
   output mp2a_pkg::pool_op_type                 q_op
);
   import mp2a_pkg::*;

   logic [SIZE_W-1:0]             cols_ff, cols_in;
   logic [SIZE_W-1:0]             rows_ff, rows_in;
   logic                          train_ff, train_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic                          accept;
   logic                          last_col;
   logic                          last_row;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign last_col  = (SIZE_W'(col_ff) + SIZE_W'(1)) >= cols_ff;
   assign last_row  = (SIZE_W'(row_ff) + SIZE_W'(1)) >= rows_ff;

   assign q_push       = accept && col_ff[0];
   assign q_op.kind    = row_ff[0] ? OP_MERGE : OP_STORE;
   assign q_op.pair    = pair_reduce(left_ff, req_sample);
   assign q_op.idx     = col_ff[COL_W-1:1];
   assign q_op.row_half = row_ff[ROW_W-1:1];
   assign q_op.train   = train_ff;

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      train_in = train_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            left_in = req_sample;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // size writes restart the raster position
      if (csr_we) begin
         if (csr_index == CSR_MAP_COLS) begin
            cols_in = eff_size(csr_wdata, MAX_COLS);
            col_in  = '0;
            row_in  = '0;
         end else if (csr_index == CSR_MAP_ROWS) begin
            rows_in = eff_size(csr_wdata, MAX_ROWS);
            col_in  = '0;
            row_in  = '0;
         end else if (csr_index == CSR_TRAINING) begin
            train_in = csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= SIZE_RESET;
         rows_ff  <= SIZE_RESET;
         train_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         train_ff <= train_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
      end
   end

endmodule

### src/mp2a_queue.sv
// ----------------------------------------------------------------------------
// mp2a_queue: short operation queue between front and back
// Small circular buffer of pooling operations.
// ----------------------------------------------------------------------------
module mp2a_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mp2a_pkg::pool_op_type push_op,
   output logic                  not_full,
   input  logic                  pop,
   output logic                  not_empty,
   output mp2a_pkg::pool_op_type head_op
);
   import mp2a_pkg::*;

   pool_op_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign not_full  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_op   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### src/mp2a_back.sv
// ----------------------------------------------------------------------------
// mp2a_back: line store and window merge
// Writes upper pair results to the line store, reads them back for the
// lower pair and registers the pooled result.
// ----------------------------------------------------------------------------
module mp2a_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mp2a_pkg::pool_op_type             q_op,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mp2a_pkg::VALUE_W-1:0]      rsp_pooled_value,
   output logic [mp2a_pkg::POS_W-1:0]        rsp_max_row,
   output logic [mp2a_pkg::POS_W-1:0]        rsp_max_col,
   output logic                              rsp_indices_valid
);
   import mp2a_pkg::*;

   pair_type                line_mem [LINE_DEPTH];
   pair_type                upper_ff;
   pool_op_type             s1_op_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]      value_ff;
   logic [POS_W-1:0]        row_ff;
   logic [POS_W-1:0]        col_ff;
   logic                    idx_valid_ff;
   logic                    out_load;
   logic                    s1_load;
   logic                    lower_wins;
   logic                    win_row;
   logic                    win_col;

   assign out_load = s1_valid_ff && (!out_valid_ff || rsp_ready);
   // stores retire at pop; merges need the read stage free
   assign q_pop    = q_valid && (q_op.kind == OP_STORE || !s1_valid_ff || out_load);
   assign s1_load  = q_pop && (q_op.kind == OP_MERGE);

   assign lower_wins = s1_op_ff.pair.best > upper_ff.best;
   assign win_row    = lower_wins;
   assign win_col    = lower_wins ? s1_op_ff.pair.pos : upper_ff.pos;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_op.kind == OP_STORE) begin
         line_mem[q_op.idx] <= q_op.pair;
      end
      if (s1_load) begin
         upper_ff <= line_mem[q_op.idx];
         s1_op_ff <= q_op;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         value_ff     <= lower_wins ? s1_op_ff.pair.best : upper_ff.best;
         idx_valid_ff <= s1_op_ff.train;
         if (s1_op_ff.train) begin
            row_ff <= POS_W'({s1_op_ff.row_half, win_row});
            col_ff <= POS_W'({s1_op_ff.idx, win_col});
         end else begin
            row_ff <= '0;
            col_ff <= '0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pooled_value  = value_ff;
   assign rsp_max_row       = row_ff;
   assign rsp_max_col       = col_ff;
   assign rsp_indices_valid = idx_valid_ff;

endmodule

### src/max_pool_2x2_argmax_top.sv
// ----------------------------------------------------------------------------
// max_pool_2x2_argmax_top: 2x2 stride-2 max pooling with argmax
// Raster stream of Q8.8 samples in, one pooled value and winner position
// out per window.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req       in         req_valid/ready    req_sample
//  rsp       out        rsp_valid/ready    pooled_value, max_row, max_col, indices_valid
//  csr       in         csr_we             csr_index, csr_wdata
//
//  one sample accepted per cycle while the operation queue has room; rsp_valid
//  rises once the bottom-right sample of its window has passed the queue entry,
//  the line store read and the output register
//  the line store takes one access per cycle and sees one per sample pair
//  req_ready drops only when the four-entry operation queue is full
//  synchronous reset clears the position counters, queue and valid flags;
//  the line store needs no clearing
// ----------------------------------------------------------------------------
module max_pool_2x2_argmax_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [mp2a_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mp2a_pkg::SIZE_W-1:0]             csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mp2a_pkg::VALUE_W-1:0]            rsp_pooled_value,
   output logic [mp2a_pkg::POS_W-1:0]              rsp_max_row,
   output logic [mp2a_pkg::POS_W-1:0]              rsp_max_col,
   output logic                                    rsp_indices_valid
);
   import mp2a_pkg::*;

   pool_op_type push_op;
   pool_op_type head_op;
   logic        push;
   logic        pop;
   logic        not_full;
   logic        not_empty;

   mp2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_ready    (not_full),
      .q_push     (push),
      .q_op       (push_op)
   );

   mp2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_op   (head_op)
   );

   mp2a_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (not_empty),
      .q_op              (head_op),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_max_row       (rsp_max_row),
      .rsp_max_col       (rsp_max_col),
      .rsp_indices_valid (rsp_indices_valid)
   );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for max_pool_2x2_argmax_top
// A scoreboard class keeps its own copy of the raster position, the line store
// of upper-pair winners and the register settings. It predicts each pooled
// window from the samples that were accepted. Directed windows cover sign
// extremes, ties and every winner position. Random phases then sweep odd,
// out-of-range and extreme map sizes and both modes. Both channels see random
// gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import mp2a_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic               iv;
   } pooled_window_type;

   class pooling_scoreboard;
      int                 errors;
      pooled_window_type  pending_windows[$];
      logic [SIZE_W-1:0]  cols_reg;
      logic [SIZE_W-1:0]  rows_reg;
      bit                 train;
      int                 line_best [LINE_DEPTH];
      int                 line_pos [LINE_DEPTH];
      int                 left_hold;
      int                 col_cnt;
      int                 row_cnt;

      function new();
         errors    = 0;
         cols_reg  = SIZE_RESET;
         rows_reg  = SIZE_RESET;
         train     = 1'b0;
         left_hold = 0;
         col_cnt   = 0;
         row_cnt   = 0;
         foreach (line_best[k]) begin
            line_best[k] = 0;
            line_pos[k]  = 0;
         end
      endfunction

      function int even_clamp(logic [SIZE_W-1:0] v, int limit);
         int e;
         e = int'(v) & ~1;
         if (e < 2) e = 2;
         if (e > limit) e = limit;
         return e;
      endfunction

      function int pending();
         return pending_windows.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t mismatch: %s", $time, msg);
      endtask

      task write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
         case (idx)
            CSR_MAP_COLS: begin
               cols_reg = data;
               col_cnt  = 0;
               row_cnt  = 0;
            end
            CSR_MAP_ROWS: begin
               rows_reg = data;
               col_cnt  = 0;
               row_cnt  = 0;
            end
            CSR_TRAINING: begin
               train = data[0];
            end
            default: ;
         endcase
      endtask

      task note_sample(logic signed [SAMPLE_BITS-1:0] s);
         int                smp;
         int                cols;
         int                rows;
         int                idx;
         int                best;
         int                pos;
         pooled_window_type w;
         smp  = int'(s);
         cols = even_clamp(cols_reg, MAX_COLS);
         rows = even_clamp(rows_reg, MAX_ROWS);
         if (col_cnt % 2 == 0) begin
            left_hold = smp;
         end else begin
            idx = col_cnt / 2;
            if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
            if (row_cnt % 2 == 0) begin
               best = 0;
               pos  = 0;
               if (left_hold > best) begin
                  best = left_hold;
                  pos  = 0;
               end
               if (smp > best) begin
                  best = smp;
                  pos  = 1;
               end
               line_best[idx] = best;
               line_pos[idx]  = pos;
            end else begin
               best = line_best[idx];
               pos  = line_pos[idx];
               if (left_hold > best) begin
                  best = left_hold;
                  pos  = 2;
               end
               if (smp > best) begin
                  best = smp;
                  pos  = 3;
               end
               w.value = best[VALUE_W-1:0];
               if (train) begin
                  w.row = POS_W'(row_cnt - 1 + pos / 2);
                  w.col = POS_W'(col_cnt - 1 + pos % 2);
                  w.iv  = 1'b1;
               end else begin
                  w.row = '0;
                  w.col = '0;
                  w.iv  = 1'b0;
               end
               pending_windows.push_back(w);
            end
         end
         if (col_cnt + 1 >= cols) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= rows) ? 0 : row_cnt + 1;
         end else begin
            col_cnt++;
         end
      endtask

      task check_result(logic [VALUE_W-1:0] value, logic [POS_W-1:0] row,
                        logic [POS_W-1:0] col, logic iv);
         pooled_window_type want;
         if (pending_windows.size() == 0) begin
            report_mismatch("pooled item with none expected");
            return;
         end
         want = pending_windows.pop_front();
         if (value !== want.value)
            report_mismatch($sformatf("pooled_value %0d, want %0d", value, want.value));
         if (row !== want.row)
            report_mismatch($sformatf("max_row %0d, want %0d", row, want.row));
         if (col !== want.col)
            report_mismatch($sformatf("max_col %0d, want %0d", col, want.col));
         if (iv !== want.iv)
            report_mismatch($sformatf("indices_valid %0b, want %0b", iv, want.iv));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [SIZE_W-1:0]             csr_wdata;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [VALUE_W-1:0]            rsp_pooled_value;
   logic [POS_W-1:0]              rsp_max_row;
   logic [POS_W-1:0]              rsp_max_col;
   logic                          rsp_indices_valid;

   pooling_scoreboard             sb;
   bit                            req_calm;
   logic signed [SAMPLE_BITS-1:0] corner [24];

   max_pool_2x2_argmax_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_max_row       (rsp_max_row),
      .rsp_max_col       (rsp_max_col),
      .rsp_indices_valid (rsp_indices_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("max_pool_2x2_argmax_top test failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return SAMPLE_BITS'($urandom());
      // near zero, to get plenty of ties
      if (r < 8) return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
      if (r == 8) return SAMPLE_BITS'(-int'($urandom_range(1, 32768)));
      case ($urandom_range(0, 4))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'sh0001;
         default: return 16'shffff;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      int gap;
      if ($urandom_range(0, 63) == 0) req_calm = ~req_calm;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
      @(negedge clock);
   endtask

   // wait until every pooled item is back and the pipe has emptied
   task automatic settle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
      @(negedge clock);
   endtask

   task automatic run_map(input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] rows,
                          input bit train, input int count);
      settle();
      csr_write(CSR_MAP_COLS, cols);
      csr_write(CSR_MAP_ROWS, rows);
      csr_write(CSR_TRAINING, SIZE_W'(train));
      repeat (count) send_sample(rand_sample());
   endtask

   initial begin : rsp_side
      int stall;
      bit calm;
      stall     = 0;
      calm      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0) calm = ~calm;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if (!calm) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_pooled_value, rsp_max_row, rsp_max_col, rsp_indices_valid);
   end

   initial begin : stimulus
      int i;
      sb         = new();
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_MAP_COLS;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_sample = '0;
      req_calm   = 1'b0;
      // windows in raster order on a 2x2 map: tl, tr, bl, br
      corner = '{16'sh8000, -16'sd1, -16'sd256, 16'sh8000,   // all negative
                 16'sd0, 16'sd0, 16'sd0, 16'sd0,             // all zero
                 16'sd100, 16'sd100, 16'sd100, 16'sd100,     // four-way tie
                 16'sd1, 16'sd32767, 16'sd5, 16'sd5,         // top-right wins
                 -16'sd3, 16'sd2, 16'sd300, 16'sd300,        // bottom-left keeps tie
                 16'sd1, 16'sd2, 16'sd3, 16'sd32767};        // bottom-right wins
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(CSR_MAP_COLS, SIZE_W'(2));
      csr_write(CSR_MAP_ROWS, SIZE_W'(2));
      csr_write(CSR_TRAINING, SIZE_W'(1));
      foreach (corner[k]) send_sample(corner[k]);

      // mode flipped between the halves of a window; unused index in between
      settle();
      csr_write(CSR_MAP_COLS, SIZE_W'(4));
      repeat (6) send_sample(rand_sample());
      settle();
      csr_write(CSR_TRAINING, SIZE_W'(0));
      repeat (2) send_sample(rand_sample());
      repeat (4) send_sample(rand_sample());
      settle();
      csr_write(CSR_UNUSED, SIZE_W'(11'h7ff));
      csr_write(CSR_TRAINING, SIZE_W'(1));
      repeat (4) send_sample(rand_sample());

      // sizes 0 and 1 clamp to 2, odd sizes drop bit 0
      run_map(SIZE_W'(0), SIZE_W'(1), 1'b1, 40);
      run_map(SIZE_W'(7), SIZE_W'(3), 1'b1, 84);
      for (i = 0; i < 5; i++)
         run_map(SIZE_W'($urandom_range(0, 20)), SIZE_W'($urandom_range(0, 10)),
                 1'($urandom_range(0, 1)), $urandom_range(80, 120));

      // wider map with a row count above the maximum
      run_map(SIZE_W'(100), SIZE_W'(2047), 1'b1, 300);
      settle();

      if (sb.errors == 0) begin
         $display("max_pool_2x2_argmax_top test passed");
      end else begin
         $display("max_pool_2x2_argmax_top test failed");
      end
      $finish;
   end

endmodule
